[design/tslp_pkg.sv]
// Shared types and constants for the trim slew limiter and DAC packer.
// No dependencies; used by tslp_calc and trim_slew_limiter_dac_packer.
package tslp_pkg;

  localparam int unsigned PosW  = 12;
  localparam int unsigned DacW  = 16;
  localparam int unsigned FldW  = 16;

  localparam logic [PosW-1:0] MidPos    = 12'd2048;
  localparam logic [PosW-1:0] MaxPos    = 12'd4095;
  localparam logic [PosW-1:0] SlewReset = 12'd20;
  localparam logic [DacW-1:0] DacTag    = 16'h9000;

  typedef enum logic {
    OP_UPDATE  = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic {
    CFG_SIDESTICK = 1'b0,
    CFG_SLEW      = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PosW-1:0] speed;
    logic [PosW-1:0] pitch;
    logic [PosW-1:0] roll;
    logic [PosW-1:0] yaw;
  } pos_t;

  typedef struct packed {
    logic [PosW-1:0] speed_trim;
    logic [PosW-1:0] pitch_trim;
    logic [PosW-1:0] roll_trim;
    logic [PosW-1:0] yaw_trim;
    logic [DacW-1:0] dac_word_a;
    logic [DacW-1:0] dac_word_b;
    logic [DacW-1:0] dac_word_c;
    logic [DacW-1:0] dac_word_d;
  } res_t;

endpackage

[design/trim_slew_limiter_dac_packer.sv]
// Top level of the four-channel trim generator with slew limiting and DAC packing.
// Depends on tslp_pkg and tslp_calc.
//
// One beat is accepted every clock cycle when the output side keeps up. A beat
// is held in an input register, passes through one combinational step that
// scales, slew-limits and clamps all four channels, and moves into the result
// register once the output side is free; the result is offered from there.
// The stored trim positions are updated as a beat moves into the result
// register, so the next beat already sees them. A release beat returns
// midpoint words and leaves the positions untouched. Configuration writes
// take effect at once and are to be made only while no beat is in flight.
module trim_slew_limiter_dac_packer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic signed [tslp_pkg::FldW-1:0]   airspeed_i,
  input  logic signed [tslp_pkg::FldW-1:0]   pitch_cmd_i,
  input  logic signed [tslp_pkg::FldW-1:0]   roll_cmd_i,
  input  logic signed [tslp_pkg::FldW-1:0]   yaw_cmd_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tslp_pkg::PosW-1:0]          speed_trim_o,
  output logic [tslp_pkg::PosW-1:0]          pitch_trim_o,
  output logic [tslp_pkg::PosW-1:0]          roll_trim_o,
  output logic [tslp_pkg::PosW-1:0]          yaw_trim_o,
  output logic [tslp_pkg::DacW-1:0]          dac_word_a_o,
  output logic [tslp_pkg::DacW-1:0]          dac_word_b_o,
  output logic [tslp_pkg::DacW-1:0]          dac_word_c_o,
  output logic [tslp_pkg::DacW-1:0]          dac_word_d_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [tslp_pkg::PosW-1:0]          cfg_data_i
);

  logic                             in_valid_q;
  tslp_pkg::op_e                    in_op_q;
  logic signed [tslp_pkg::FldW-1:0] airspeed_q, pitch_cmd_q, roll_cmd_q, yaw_cmd_q;
  logic                             out_valid_q;
  tslp_pkg::res_t                   out_q;
  tslp_pkg::pos_t                   pos_q;
  logic                             sidestick_q;
  logic [tslp_pkg::PosW-1:0]        slew_q;

  tslp_pkg::pos_t                   pos_d;
  tslp_pkg::res_t                   res_d;
  logic                             out_free;
  logic                             move;
  logic                             in_accept;
  tslp_pkg::cfg_idx_e               cfg_idx;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign move       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_idx    = tslp_pkg::cfg_idx_e'(cfg_idx_i);

  tslp_calc u_calc (
    .op_i        (in_op_q),
    .airspeed_i  (airspeed_q),
    .pitch_cmd_i (pitch_cmd_q),
    .roll_cmd_i  (roll_cmd_q),
    .yaw_cmd_i   (yaw_cmd_q),
    .sidestick_i (sidestick_q),
    .slew_i      (slew_q),
    .pos_i       (pos_q),
    .pos_o       (pos_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '{tslp_pkg::MidPos, tslp_pkg::MidPos, tslp_pkg::MidPos,
                       tslp_pkg::MidPos};
      sidestick_q <= 1'b0;
      slew_q      <= tslp_pkg::SlewReset;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (move) begin
        in_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
        pos_q       <= pos_d;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx)
          tslp_pkg::CFG_SIDESTICK: sidestick_q <= cfg_data_i[0];
          tslp_pkg::CFG_SLEW:      slew_q      <= cfg_data_i;
          default:                 slew_q      <= slew_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q     <= tslp_pkg::op_e'(op_i);
      airspeed_q  <= airspeed_i;
      pitch_cmd_q <= pitch_cmd_i;
      roll_cmd_q  <= roll_cmd_i;
      yaw_cmd_q   <= yaw_cmd_i;
    end
    if (move) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign speed_trim_o = out_q.speed_trim;
  assign pitch_trim_o = out_q.pitch_trim;
  assign roll_trim_o  = out_q.roll_trim;
  assign yaw_trim_o   = out_q.yaw_trim;
  assign dac_word_a_o = out_q.dac_word_a;
  assign dac_word_b_o = out_q.dac_word_b;
  assign dac_word_c_o = out_q.dac_word_c;
  assign dac_word_d_o = out_q.dac_word_d;

  // A release beat must leave every stored position as it was.
  a_release_keeps_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && (in_op_q == tslp_pkg::OP_RELEASE) |=> pos_q == $past(pos_q))
    else $error("release beat changed a trim position");

  // The input side stalls only behind a held, stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a stalled result");

  // The airspeed trim never drops below the midpoint.
  a_speed_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.speed_trim >= tslp_pkg::MidPos)
    else $error("speed trim below midpoint");

endmodule

[design/tslp_calc.sv]
// Single-pass trim calculation: scaling, slew limiting, clamping and DAC packing.
// Depends on tslp_pkg.
module tslp_calc (
  input  tslp_pkg::op_e                       op_i,
  input  logic signed [tslp_pkg::FldW-1:0]    airspeed_i,
  input  logic signed [tslp_pkg::FldW-1:0]    pitch_cmd_i,
  input  logic signed [tslp_pkg::FldW-1:0]    roll_cmd_i,
  input  logic signed [tslp_pkg::FldW-1:0]    yaw_cmd_i,
  input  logic                                sidestick_i,
  input  logic [tslp_pkg::PosW-1:0]           slew_i,
  input  tslp_pkg::pos_t                      pos_i,
  output tslp_pkg::pos_t                      pos_o,
  output tslp_pkg::res_t                      res_o
);

  localparam int unsigned TgtW = 19;
  localparam logic [23:0] SpeedRecip = 24'd8589935;

  function automatic logic signed [12:0] div8(input logic signed [15:0] q);
    logic signed [16:0] t;
    t = {q[15], q} + (q[15] ? 17'sd7 : 17'sd0);
    return t[15:3];
  endfunction

  function automatic logic [11:0] limit_clamp(input logic signed [TgtW-1:0] t,
                                              input logic [11:0] p,
                                              input logic [11:0] s,
                                              input logic signed [TgtW-1:0] lo);
    logic signed [TgtW-1:0] hi_b;
    logic signed [TgtW-1:0] lo_b;
    logic signed [TgtW-1:0] r;
    hi_b = $signed({7'd0, p}) + $signed({7'd0, s});
    lo_b = $signed({7'd0, p}) - $signed({7'd0, s});
    if (t > hi_b) begin
      r = hi_b;
    end else if (t < lo_b) begin
      r = lo_b;
    end else begin
      r = t;
    end
    if (r < lo) begin
      r = lo;
    end else if (r > $signed({7'd0, tslp_pkg::MaxPos})) begin
      r = $signed({7'd0, tslp_pkg::MaxPos});
    end
    return r[11:0];
  endfunction

  function automatic logic [15:0] dac(input logic [11:0] p);
    return tslp_pkg::DacTag | {4'd0, tslp_pkg::MaxPos - p};
  endfunction

  logic signed [tslp_pkg::FldW-1:0] vq, eq, aq, rq;
  logic [15:0]                      vmag;
  logic [39:0]                      vprod;
  logic [15:0]                      vquo;
  logic signed [TgtW-1:0]           vt, et, at, rt, mid;
  tslp_pkg::pos_t                   upd;
  tslp_pkg::pos_t                   shown;

  always_comb begin
    vq = sidestick_i ? '0 : airspeed_i;
    eq = sidestick_i ? '0 : pitch_cmd_i;
    aq = sidestick_i ? '0 : roll_cmd_i;
    rq = sidestick_i ? '0 : yaw_cmd_i;

    // Magnitude times 128/125 by a scaled reciprocal, then the sign restored.
    vmag  = vq[15] ? (~vq + 16'd1) : vq;
    vprod = {24'd0, vmag} * {16'd0, SpeedRecip};
    vquo  = vprod[38:23];

    mid = $signed({7'd0, tslp_pkg::MidPos});
    vt  = vq[15] ? (mid - $signed({3'd0, vquo})) : (mid + $signed({3'd0, vquo}));
    et  = mid + TgtW'(div8(eq));
    at  = mid + TgtW'(div8(aq));
    rt  = mid + TgtW'(div8(rq));

    upd.speed = limit_clamp(vt, pos_i.speed, slew_i, mid);
    upd.pitch = limit_clamp(et, pos_i.pitch, slew_i, '0);
    upd.roll  = limit_clamp(at, pos_i.roll,  slew_i, '0);
    upd.yaw   = limit_clamp(rt, pos_i.yaw,   slew_i, '0);

    if (op_i == tslp_pkg::OP_RELEASE) begin
      pos_o = pos_i;
      shown = '{tslp_pkg::MidPos, tslp_pkg::MidPos, tslp_pkg::MidPos, tslp_pkg::MidPos};
    end else begin
      pos_o = upd;
      shown = upd;
    end

    res_o.speed_trim = shown.speed;
    res_o.pitch_trim = shown.pitch;
    res_o.roll_trim  = shown.roll;
    res_o.yaw_trim   = shown.yaw;
    res_o.dac_word_a = dac(shown.yaw);
    res_o.dac_word_b = dac(shown.speed);
    res_o.dac_word_c = dac(shown.pitch);
    res_o.dac_word_d = dac(shown.roll);
  end

endmodule

[tb/trim_slew_limiter_dac_packer_tb.sv]
// Self-checking testbench for the trim slew limiter and DAC packer.
// Needs tslp_pkg and trim_slew_limiter_dac_packer; predicts every result beat
// and checks it field by field.
`timescale 1ns / 100ps

module trim_slew_limiter_dac_packer_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBeats = 230;
  localparam int unsigned LongHold   = 120;

  typedef struct {
    tslp_pkg::op_e                      op;
    logic signed [tslp_pkg::FldW-1:0]   airspeed;
    logic signed [tslp_pkg::FldW-1:0]   pitch_cmd;
    logic signed [tslp_pkg::FldW-1:0]   roll_cmd;
    logic signed [tslp_pkg::FldW-1:0]   yaw_cmd;
  } stick_beat_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  stick_beat_t                 cur_beat = '{tslp_pkg::OP_UPDATE, '0, '0, '0, '0};
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [tslp_pkg::PosW-1:0]   speed_trim, pitch_trim, roll_trim, yaw_trim;
  logic [tslp_pkg::DacW-1:0]   dac_word_a, dac_word_b, dac_word_c, dac_word_d;
  logic                        cfg_we = 1'b0;
  tslp_pkg::cfg_idx_e          cfg_idx = tslp_pkg::CFG_SIDESTICK;
  logic [tslp_pkg::PosW-1:0]   cfg_data = '0;

  tslp_pkg::pos_t              trim_pos = '{tslp_pkg::MidPos, tslp_pkg::MidPos,
                                            tslp_pkg::MidPos, tslp_pkg::MidPos};
  logic                        side_mode = 1'b0;
  logic [tslp_pkg::PosW-1:0]   slew_lim = tslp_pkg::SlewReset;

  stick_beat_t                 beat_q[$];
  tslp_pkg::res_t              trim_exp_q[$];
  int unsigned                 err_cnt = 0;
  int unsigned                 res_cnt = 0;
  int unsigned                 cycle_cnt = 0;
  int unsigned                 gap_cnt = 0;
  int unsigned                 stall_cnt = 0;
  bit                          long_hold_done = 1'b0;
  bit                          pace_en = 1'b0;

  trim_slew_limiter_dac_packer u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (cur_beat.op),
    .airspeed_i   (cur_beat.airspeed),
    .pitch_cmd_i  (cur_beat.pitch_cmd),
    .roll_cmd_i   (cur_beat.roll_cmd),
    .yaw_cmd_i    (cur_beat.yaw_cmd),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .speed_trim_o (speed_trim),
    .pitch_trim_o (pitch_trim),
    .roll_trim_o  (roll_trim),
    .yaw_trim_o   (yaw_trim),
    .dac_word_a_o (dac_word_a),
    .dac_word_b_o (dac_word_b),
    .dac_word_c_o (dac_word_c),
    .dac_word_d_o (dac_word_d),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [tslp_pkg::PosW-1:0] slew_clamp(
      int target, logic [tslp_pkg::PosW-1:0] pos, int lo);
    int p = pos;
    int s = slew_lim;
    int top = tslp_pkg::MaxPos;
    int t = target;
    if (t > p + s) begin
      t = p + s;
    end else if (t < p - s) begin
      t = p - s;
    end
    if (t < lo) begin
      t = lo;
    end else if (t > top) begin
      t = top;
    end
    return t[tslp_pkg::PosW-1:0];
  endfunction

  function automatic logic [tslp_pkg::DacW-1:0] dac_pack(logic [tslp_pkg::PosW-1:0] pos);
    return tslp_pkg::DacTag |
           {{(tslp_pkg::DacW-tslp_pkg::PosW){1'b0}}, tslp_pkg::MaxPos - pos};
  endfunction

  // Works out the result of one accepted beat; an update beat moves the trim positions on.
  function automatic tslp_pkg::res_t trim_predict(stick_beat_t b);
    int             mid = tslp_pkg::MidPos;
    int             vq = b.airspeed;
    int             eq = b.pitch_cmd;
    int             aq = b.roll_cmd;
    int             rq = b.yaw_cmd;
    tslp_pkg::pos_t p;
    tslp_pkg::res_t r;
    if (b.op == tslp_pkg::OP_RELEASE) begin
      p = '{tslp_pkg::MidPos, tslp_pkg::MidPos, tslp_pkg::MidPos, tslp_pkg::MidPos};
    end else begin
      if (side_mode) begin
        vq = 0;
        eq = 0;
        aq = 0;
        rq = 0;
      end
      trim_pos.speed = slew_clamp(mid + (vq * 128) / 125, trim_pos.speed, mid);
      trim_pos.pitch = slew_clamp(mid + eq / 8, trim_pos.pitch, 0);
      trim_pos.roll  = slew_clamp(mid + aq / 8, trim_pos.roll, 0);
      trim_pos.yaw   = slew_clamp(mid + rq / 8, trim_pos.yaw, 0);
      p = trim_pos;
    end
    r.speed_trim = p.speed;
    r.pitch_trim = p.pitch;
    r.roll_trim  = p.roll;
    r.yaw_trim   = p.yaw;
    r.dac_word_a = dac_pack(p.yaw);
    r.dac_word_b = dac_pack(p.speed);
    r.dac_word_c = dac_pack(p.pitch);
    r.dac_word_d = dac_pack(p.roll);
    return r;
  endfunction

  function automatic int unsigned pick_pause();
    int unsigned r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [tslp_pkg::FldW-1:0] rand_cmd();
    int tmp;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: tmp = $urandom;
      4, 5, 6: tmp = int'($urandom_range(0, 32768)) - 16384;
      7: begin
        case ($urandom_range(0, 3))
          0: tmp = 32'h7FFF;
          1: tmp = 32'h8000;
          2: tmp = 0;
          default: tmp = -1;
        endcase
      end
      default: tmp = int'($urandom_range(0, 128)) - 64;
    endcase
    return tmp[tslp_pkg::FldW-1:0];
  endfunction

  function automatic logic signed [tslp_pkg::FldW-1:0] rand_speed();
    int tmp;
    case ($urandom_range(0, 9))
      0, 1, 2: tmp = $urandom;
      3, 4, 5, 6, 7: tmp = $urandom_range(0, 4000);
      8: tmp = $urandom_range(0, 1) ? 32'h7FFF : 32'h8000;
      default: tmp = int'($urandom_range(0, 400)) - 200;
    endcase
    return tmp[tslp_pkg::FldW-1:0];
  endfunction

  function automatic stick_beat_t rand_beat();
    stick_beat_t b;
    b.op        = ($urandom_range(0, 9) == 0) ? tslp_pkg::OP_RELEASE : tslp_pkg::OP_UPDATE;
    b.airspeed  = rand_speed();
    b.pitch_cmd = rand_cmd();
    b.roll_cmd  = rand_cmd();
    b.yaw_cmd   = rand_cmd();
    return b;
  endfunction

  function automatic void check_field(string fld, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fld, want, got);
    end
  endfunction

  task automatic push_beat(tslp_pkg::op_e op,
                           logic signed [tslp_pkg::FldW-1:0] spd,
                           logic signed [tslp_pkg::FldW-1:0] ptc,
                           logic signed [tslp_pkg::FldW-1:0] rol,
                           logic signed [tslp_pkg::FldW-1:0] yaw);
    beat_q.push_back('{op, spd, ptc, rol, yaw});
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (beat_q.size() != 0 || in_valid || trim_exp_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(tslp_pkg::cfg_idx_e idx, logic [tslp_pkg::PosW-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tslp_pkg::CFG_SIDESTICK) begin
      side_mode = val[0];
    end else begin
      slew_lim = val;
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin : driver
    stick_beat_t nb;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_cnt  <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        trim_exp_q.push_back(trim_predict(cur_beat));
      end
      if (!in_valid || !in_stall) begin
        if (gap_cnt != 0) begin
          in_valid <= 1'b0;
          gap_cnt  <= gap_cnt - 1;
        end else if (beat_q.size() != 0) begin
          nb = beat_q.pop_front();
          cur_beat <= nb;
          in_valid <= 1'b1;
          gap_cnt  <= pace_en ? pick_pause() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold backs the block up; paced phases add random holds.
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cnt <= 0;
    end else if (!long_hold_done && res_cnt >= 400) begin
      long_hold_done <= 1'b1;
      out_stall      <= 1'b1;
      stall_cnt      <= LongHold;
    end else if (stall_cnt != 0) begin
      out_stall <= 1'b1;
      stall_cnt <= stall_cnt - 1;
    end else if (pace_en && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_cnt <= pick_pause();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : monitor
    tslp_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      res_cnt <= res_cnt + 1;
      if (trim_exp_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result beat with none expected, got speed 0x%0h pitch 0x%0h",
                 $time, speed_trim, pitch_trim);
      end else begin
        want = trim_exp_q.pop_front();
        check_field("speed_trim", want.speed_trim, speed_trim);
        check_field("pitch_trim", want.pitch_trim, pitch_trim);
        check_field("roll_trim", want.roll_trim, roll_trim);
        check_field("yaw_trim", want.yaw_trim, yaw_trim);
        check_field("dac_word_a", want.dac_word_a, dac_word_a);
        check_field("dac_word_b", want.dac_word_b, dac_word_b);
        check_field("dac_word_c", want.dac_word_c, dac_word_c);
        check_field("dac_word_d", want.dac_word_d, dac_word_d);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic                      ph_side[8];
    logic [tslp_pkg::PosW-1:0] ph_slew[8];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_beat(tslp_pkg::OP_UPDATE, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    push_beat(tslp_pkg::OP_UPDATE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_beat(tslp_pkg::OP_UPDATE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_beat(tslp_pkg::OP_RELEASE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_beat(tslp_pkg::OP_UPDATE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    push_beat(tslp_pkg::OP_UPDATE, -16'sd1, -16'sd7, -16'sd9, 16'sd7);
    push_beat(tslp_pkg::OP_UPDATE, 16'sh4000, 16'shC000, 16'sh0008, 16'shFFF8);
    wait_drained();

    cfg_write(tslp_pkg::CFG_SLEW, tslp_pkg::MaxPos);
    push_beat(tslp_pkg::OP_UPDATE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_beat(tslp_pkg::OP_UPDATE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    push_beat(tslp_pkg::OP_RELEASE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    push_beat(tslp_pkg::OP_UPDATE, 16'sd2000, 16'sh3FF8, 16'shC000, 16'sh0000);
    push_beat(tslp_pkg::OP_UPDATE, 16'sd1999, -16'sd1, 16'sh5555, 16'shAAAA);
    push_beat(tslp_pkg::OP_UPDATE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    wait_drained();

    cfg_write(tslp_pkg::CFG_SIDESTICK, 12'd1);
    cfg_write(tslp_pkg::CFG_SLEW, 12'd100);
    push_beat(tslp_pkg::OP_UPDATE, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    push_beat(tslp_pkg::OP_UPDATE, 16'sh1234, 16'sh5678, 16'sh9ABC, 16'shDEF0);
    push_beat(tslp_pkg::OP_RELEASE, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    wait_drained();

    cfg_write(tslp_pkg::CFG_SIDESTICK, 12'd0);
    cfg_write(tslp_pkg::CFG_SLEW, 12'd0);
    push_beat(tslp_pkg::OP_UPDATE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    push_beat(tslp_pkg::OP_UPDATE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    wait_drained();

    ph_side = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    ph_slew[0] = tslp_pkg::SlewReset;
    ph_slew[1] = tslp_pkg::MaxPos;
    ph_slew[2] = 12'd0;
    ph_slew[3] = 12'd1;
    ph_slew[4] = 12'($urandom_range(0, 4095));
    ph_slew[5] = 12'($urandom_range(1, 64));
    ph_slew[6] = tslp_pkg::MaxPos;
    ph_slew[7] = 12'($urandom_range(0, 4095));

    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(tslp_pkg::CFG_SIDESTICK, {{(tslp_pkg::PosW-1){1'b0}}, ph_side[ph]});
      cfg_write(tslp_pkg::CFG_SLEW, ph_slew[ph]);
      pace_en = (ph != 3);
      for (int n = 0; n < PhaseBeats; n++) begin
        beat_q.push_back(rand_beat());
      end
      wait_drained();
    end

    pace_en = 1'b0;
    wait_drained();
    if (err_cnt == 0 && trim_exp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
